FILE: rtl/gdft_pkg.sv
// ----------------------------------------------------------------------------
// gdft_pkg
// Shared widths, command codes and sequencer states of the depth-first
// traversal block.
// ----------------------------------------------------------------------------
package gdft_pkg;

   localparam int VERTEX_W = 7;
   localparam int CMD_W    = 2;

   typedef logic [VERTEX_W-1:0] vertex_type;
   typedef logic [CMD_W-1:0]    cmd_type;

   localparam cmd_type CMD_CLEAR = 2'd0;
   localparam cmd_type CMD_EDGE  = 2'd1;
   localparam cmd_type CMD_RUN   = 2'd2;

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_EDGE_RD   = 10'b00_0000_0010,
      ST_EDGE_WR   = 10'b00_0000_0100,
      ST_EDGE_LINK = 10'b00_0000_1000,
      ST_FETCH     = 10'b00_0001_0000,
      ST_SCAN      = 10'b00_0010_0000,
      ST_CHECK     = 10'b00_0100_0000,
      ST_EMIT      = 10'b00_1000_0000,
      ST_POP_RD    = 10'b01_0000_0000,
      ST_DONE      = 10'b10_0000_0000
   } state_type;

endpackage

FILE: rtl/gdft_if.sv
// ----------------------------------------------------------------------------
// gdft request and response channels
// Valid/ready channels carrying command words in and visited vertices out.
// ----------------------------------------------------------------------------
interface gdft_req_if import gdft_pkg::*; ();
   logic       valid;
   logic       ready;
   cmd_type    cmd;
   vertex_type end_a;
   vertex_type end_b;

   modport source (output valid, output cmd, output end_a, output end_b, input ready);
   modport sink   (input valid, input cmd, input end_a, input end_b, output ready);
endinterface

interface gdft_rsp_if import gdft_pkg::*; ();
   logic       valid;
   logic       ready;
   vertex_type vertex;
   logic       last;

   modport source (output valid, output vertex, output last, input ready);
   modport sink   (input valid, input vertex, input last, output ready);
endinterface

FILE: rtl/graph_depth_first_traversal_top.sv
// ----------------------------------------------------------------------------
// Clear completes at its accepting edge; an edge load does a list read and an
//   entry write per endpoint, plus a tail link write when that list is not empty.
//   One command word at a time, accepted only in idle. A run step fetches list
//   head and cursor, checks each list entry examined and ends in an emit or a
//   pop; the last pop sends the final word. A stalled result holds the walk.
// Reset: lists, cursors and visited flags read as empty at once; vertex_count 64.
// ----------------------------------------------------------------------------
// graph_depth_first_traversal_top
// Loads an undirected graph as per-vertex linked neighbor lists and emits the
// depth-first visiting order from a start vertex.
// ----------------------------------------------------------------------------
module graph_depth_first_traversal_top import gdft_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256
) (
   input  logic                clock,
   input  logic                reset,
   gdft_req_if.sink            req_if,
   gdft_rsp_if.source          rsp_if,
   input  logic                csr_wr_en,
   input  logic [VERTEX_W-1:0] csr_wr_data
);

   localparam int ENTRY_CAP = 2 * MAX_EDGES;
   localparam int LINK_W    = $clog2(ENTRY_CAP);
   localparam int PTR_W     = LINK_W + 1;
   localparam int CNT_W     = $clog2(ENTRY_CAP + 1);
   localparam int VI_W      = $clog2(MAX_VERTICES);
   localparam int DEP_W     = $clog2(MAX_VERTICES + 1);

   localparam logic [PTR_W-1:0]    NIL      = {PTR_W{1'b1}};
   localparam logic [CNT_W:0]      CAP_EXT  = (CNT_W + 1)'(ENTRY_CAP);
   localparam logic [DEP_W-1:0]    MAXV_D   = DEP_W'(MAX_VERTICES);
   localparam logic [VERTEX_W-1:0] MAXV_V   = VERTEX_W'(MAX_VERTICES);
   localparam logic [DEP_W-1:0]    ONE_D    = DEP_W'(1);
   localparam logic [DEP_W-1:0]    TWO_D    = DEP_W'(2);

   // control registers
   state_type              state_ff, state_in;
   vertex_type             vcount_ff, vcount_in;
   logic                   second_ff, second_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [MAX_VERTICES-1:0] head_valid_ff, head_valid_in;
   logic [MAX_VERTICES-1:0] cursor_valid_ff, cursor_valid_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [DEP_W-1:0]       depth_ff, depth_in;
   logic [DEP_W-1:0]       n_ff, n_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload registers
   vertex_type             owner_ff, owner_in;
   vertex_type             nb_ff, nb_in;
   logic [LINK_W-1:0]      tail_ff, tail_in;
   logic [LINK_W-1:0]      link_e_ff, link_e_in;
   vertex_type             top_ff, top_in;
   vertex_type             pend_ff, pend_in;
   vertex_type             found_ff, found_in;
   vertex_type             rsp_vertex_ff, rsp_vertex_in;
   logic                   rsp_last_ff, rsp_last_in;

   // memory ports
   logic                   nbr_wr_en, next_wr_en, entry_rd_en;
   logic [LINK_W-1:0]      nbr_wr_addr, next_wr_addr, entry_rd_addr;
   vertex_type             nbr_wr_data, nbr_rd_data;
   logic [PTR_W-1:0]       next_wr_data, next_rd_data;

   logic                   list_wr_en, list_rd_en;
   logic [VI_W-1:0]        list_wr_addr, list_rd_addr;
   logic [2*LINK_W-1:0]    list_wr_data, list_rd_data;

   logic                   cursor_wr_en, cursor_rd_en;
   logic [VI_W-1:0]        cursor_wr_addr, cursor_rd_addr;
   logic [PTR_W-1:0]       cursor_wr_data, cursor_rd_data;

   logic                   stack_wr_en, stack_rd_en;
   logic [VI_W-1:0]        stack_wr_addr, stack_rd_addr;
   vertex_type             stack_wr_data, stack_rd_data;

   // helpers
   vertex_type             live_count;
   logic                   out_free;
   logic                   fits;
   logic [VI_W-1:0]        a_idx, owner_idx, top_idx, cand_idx;
   logic [LINK_W-1:0]      list_rd_head, list_rd_tail, entry_idx;
   logic [PTR_W-1:0]       cur_sel;
   logic                   cand_ok;
   logic                   do_pop;

   function automatic logic in_range(input vertex_type v, input vertex_type lim);
      return (v != '0) && (v <= lim);
   endfunction

   assign live_count   = (vcount_ff > MAXV_V) ? MAXV_V : vcount_ff;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign fits         = ({1'b0, count_ff} + (CNT_W + 1)'(2)) <= CAP_EXT;
   assign a_idx        = VI_W'(req_if.end_a - 7'd1);
   assign owner_idx    = VI_W'(owner_ff - 7'd1);
   assign top_idx      = VI_W'(top_ff - 7'd1);
   assign cand_idx     = VI_W'(nbr_rd_data - 7'd1);
   assign cand_ok      = (nbr_rd_data != '0) && (nbr_rd_data <= MAXV_V);
   assign list_rd_head = list_rd_data[2*LINK_W-1:LINK_W];
   assign list_rd_tail = list_rd_data[LINK_W-1:0];
   assign entry_idx    = count_ff[LINK_W-1:0];

   // a vertex whose cursor was not touched this run scans from its list head
   assign cur_sel = cursor_valid_ff[top_idx] ? cursor_rd_data :
                    (head_valid_ff[top_idx] ? {1'b0, list_rd_head} : NIL);

   always_comb begin
      state_in        = state_ff;
      vcount_in       = vcount_ff;
      second_in       = second_ff;
      count_in        = count_ff;
      head_valid_in   = head_valid_ff;
      cursor_valid_in = cursor_valid_ff;
      visited_in      = visited_ff;
      depth_in        = depth_ff;
      n_in            = n_ff;
      owner_in        = owner_ff;
      nb_in           = nb_ff;
      tail_in         = tail_ff;
      link_e_in       = link_e_ff;
      top_in          = top_ff;
      pend_in         = pend_ff;
      found_in        = found_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      rsp_vertex_in   = rsp_vertex_ff;
      rsp_last_in     = rsp_last_ff;

      nbr_wr_en      = 1'b0;
      nbr_wr_addr    = entry_idx;
      nbr_wr_data    = nb_ff;
      next_wr_en     = 1'b0;
      next_wr_addr   = entry_idx;
      next_wr_data   = NIL;
      entry_rd_en    = 1'b0;
      entry_rd_addr  = cur_sel[LINK_W-1:0];
      list_wr_en     = 1'b0;
      list_wr_addr   = owner_idx;
      list_wr_data   = {entry_idx, entry_idx};
      list_rd_en     = 1'b0;
      list_rd_addr   = top_idx;
      cursor_wr_en   = 1'b0;
      cursor_wr_addr = top_idx;
      cursor_wr_data = next_rd_data;
      cursor_rd_en   = 1'b0;
      cursor_rd_addr = top_idx;
      stack_wr_en    = 1'b0;
      stack_wr_addr  = VI_W'(depth_ff - ONE_D);
      stack_wr_data  = top_ff;
      stack_rd_en    = 1'b0;
      stack_rd_addr  = VI_W'(depth_ff - TWO_D);
      do_pop         = 1'b0;

      if (csr_wr_en) begin
         vcount_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               case (req_if.cmd)
                  CMD_CLEAR: begin
                     head_valid_in   = '0;
                     cursor_valid_in = '0;
                     visited_in      = '0;
                     count_in        = '0;
                     depth_in        = '0;
                  end
                  CMD_EDGE: begin
                     if (in_range(req_if.end_a, live_count) &&
                         in_range(req_if.end_b, live_count) && fits) begin
                        owner_in  = req_if.end_a;
                        nb_in     = req_if.end_b;
                        second_in = 1'b0;
                        state_in  = ST_EDGE_RD;
                     end
                  end
                  CMD_RUN: begin
                     if (in_range(req_if.end_a, live_count)) begin
                        visited_in        = '0;
                        visited_in[a_idx] = 1'b1;
                        cursor_valid_in   = '0;
                        top_in            = req_if.end_a;
                        pend_in           = req_if.end_a;
                        depth_in          = ONE_D;
                        n_in              = ONE_D;
                        state_in          = ST_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EDGE_RD: begin
            list_rd_en   = 1'b1;
            list_rd_addr = owner_idx;
            state_in     = ST_EDGE_WR;
         end
         ST_EDGE_WR: begin
            nbr_wr_en    = 1'b1;
            next_wr_en   = 1'b1;
            list_wr_en   = 1'b1;
            list_wr_data = {(head_valid_ff[owner_idx] ? list_rd_head : entry_idx), entry_idx};
            head_valid_in[owner_idx] = 1'b1;
            count_in     = count_ff + CNT_W'(1);
            tail_in      = list_rd_tail;
            link_e_in    = entry_idx;
            if (head_valid_ff[owner_idx]) begin
               state_in = ST_EDGE_LINK;
            end else if (!second_ff) begin
               second_in = 1'b1;
               owner_in  = nb_ff;
               nb_in     = owner_ff;
               state_in  = ST_EDGE_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EDGE_LINK: begin
            // old tail now points at the new entry
            next_wr_en   = 1'b1;
            next_wr_addr = tail_ff;
            next_wr_data = {1'b0, link_e_ff};
            if (!second_ff) begin
               second_in = 1'b1;
               owner_in  = nb_ff;
               nb_in     = owner_ff;
               state_in  = ST_EDGE_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            list_rd_en   = 1'b1;
            cursor_rd_en = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (cur_sel[LINK_W]) begin
               do_pop = 1'b1;
            end else begin
               entry_rd_en   = 1'b1;
               entry_rd_addr = cur_sel[LINK_W-1:0];
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cand_ok && !visited_ff[cand_idx]) begin
               cursor_wr_en             = 1'b1;
               cursor_valid_in[top_idx] = 1'b1;
               if ((n_ff < MAXV_D) && (depth_ff < MAXV_D)) begin
                  visited_in[cand_idx] = 1'b1;
                  stack_wr_en          = 1'b1;
                  top_in               = nbr_rd_data;
                  found_in             = nbr_rd_data;
                  depth_in             = depth_ff + ONE_D;
                  n_in                 = n_ff + ONE_D;
                  state_in             = ST_EMIT;
               end else begin
                  do_pop = 1'b1;
               end
            end else if (next_rd_data[LINK_W]) begin
               do_pop = 1'b1;
            end else begin
               entry_rd_en   = 1'b1;
               entry_rd_addr = next_rd_data[LINK_W-1:0];
            end
         end
         ST_EMIT: begin
            // the held vertex is known not to be last once another is found
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = pend_ff;
               rsp_last_in   = 1'b0;
               pend_in       = found_ff;
               state_in      = ST_FETCH;
            end
         end
         ST_POP_RD: begin
            top_in   = stack_rd_data;
            state_in = ST_FETCH;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = pend_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_pop) begin
         depth_in = depth_ff - ONE_D;
         if (depth_ff == ONE_D) begin
            state_in = ST_DONE;
         end else begin
            stack_rd_en = 1'b1;
            state_in    = ST_POP_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         vcount_ff       <= 7'd64;
         second_ff       <= 1'b0;
         count_ff        <= '0;
         head_valid_ff   <= '0;
         cursor_valid_ff <= '0;
         visited_ff      <= '0;
         depth_ff        <= '0;
         n_ff            <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         vcount_ff       <= vcount_in;
         second_ff       <= second_in;
         count_ff        <= count_in;
         head_valid_ff   <= head_valid_in;
         cursor_valid_ff <= cursor_valid_in;
         visited_ff      <= visited_in;
         depth_ff        <= depth_in;
         n_ff            <= n_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      owner_ff      <= owner_in;
      nb_ff         <= nb_in;
      tail_ff       <= tail_in;
      link_e_ff     <= link_e_in;
      top_ff        <= top_in;
      pend_ff       <= pend_in;
      found_ff      <= found_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.vertex = rsp_vertex_ff;
   assign rsp_if.last   = rsp_last_ff;

   gdft_ram #(.WIDTH(VERTEX_W), .DEPTH(ENTRY_CAP)) u_neighbor_ram (
      .clock   (clock),
      .wr_en   (nbr_wr_en),
      .wr_addr (nbr_wr_addr),
      .wr_data (nbr_wr_data),
      .rd_en   (entry_rd_en),
      .rd_addr (entry_rd_addr),
      .rd_data (nbr_rd_data)
   );

   gdft_ram #(.WIDTH(PTR_W), .DEPTH(ENTRY_CAP)) u_next_link_ram (
      .clock   (clock),
      .wr_en   (next_wr_en),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_en   (entry_rd_en),
      .rd_addr (entry_rd_addr),
      .rd_data (next_rd_data)
   );

   gdft_ram #(.WIDTH(2 * LINK_W), .DEPTH(MAX_VERTICES)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_addr (list_wr_addr),
      .wr_data (list_wr_data),
      .rd_en   (list_rd_en),
      .rd_addr (list_rd_addr),
      .rd_data (list_rd_data)
   );

   gdft_ram #(.WIDTH(PTR_W), .DEPTH(MAX_VERTICES)) u_cursor_ram (
      .clock   (clock),
      .wr_en   (cursor_wr_en),
      .wr_addr (cursor_wr_addr),
      .wr_data (cursor_wr_data),
      .rd_en   (cursor_rd_en),
      .rd_addr (cursor_rd_addr),
      .rd_data (cursor_rd_data)
   );

   gdft_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_VERTICES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (stack_wr_addr),
      .wr_data (stack_wr_data),
      .rd_en   (stack_rd_en),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd_data)
   );

   // entry memory never overfills
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRY_CAP))
      else $error("entry count beyond capacity");

   // walking states always have a vertex on the stack
   a_depth_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH || state_ff == ST_SCAN || state_ff == ST_CHECK ||
       state_ff == ST_EMIT || state_ff == ST_POP_RD) |-> (depth_ff != '0))
      else $error("traversal step with empty stack");

   // a found vertex releases the held one as a non-final word
   a_emit_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (rsp_valid_ff && !rsp_last_ff))
      else $error("intermediate word not presented");

   // run ends with a final word and returns to idle
   a_done_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=>
         (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("final word not presented");

endmodule

FILE: rtl/gdft_ram.sv
// ----------------------------------------------------------------------------
// gdft_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gdft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
